>>> rtl/core/stls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stls_pkg
// Shared types and constants of the script lexer token splitter.
// ----------------------------------------------------------------------------
package stls_pkg;

  localparam longint unsigned MAX_TOKEN_LENGTH = 65535;
  localparam int LEN_W = 16;
  localparam logic [LEN_W-1:0] LEN_CAP =
    (MAX_TOKEN_LENGTH < 64'hFFFF) ? LEN_W'(MAX_TOKEN_LENGTH) : 16'hFFFF;

  localparam int CLS_W = 3;
  localparam logic [CLS_W-1:0] CLS_SPACE  = 3'd0;
  localparam logic [CLS_W-1:0] CLS_LINE   = 3'd1;
  localparam logic [CLS_W-1:0] CLS_BLOCK  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_STRING = 3'd3;
  localparam logic [CLS_W-1:0] CLS_WORD   = 3'd4;
  localparam logic [CLS_W-1:0] CLS_PUNCT  = 3'd5;
  localparam logic [CLS_W-1:0] CLS_ERROR  = 3'd6;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [LEN_W-1:0] len;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/core/stls_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stls_if
// Valid/ready channels for source bytes and token results.
// ----------------------------------------------------------------------------
interface stls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       buffer_end;

  modport source (output valid, source_byte, buffer_end, input ready);
  modport sink (input valid, source_byte, buffer_end, output ready);
endinterface

interface stls_out_if;
  logic                      valid;
  logic                      ready;
  logic [stls_pkg::CLS_W-1:0] token_class;
  logic [stls_pkg::LEN_W-1:0] token_length;
  logic                      last_of_run;

  modport source (output valid, token_class, token_length, last_of_run, input ready);
  modport sink (input valid, token_class, token_length, last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/core/stls_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stls_front
// Lexer state machine: classify each byte, track the open token and build
// the results that the byte causes.
// ----------------------------------------------------------------------------
module stls_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  stls_in_if.sink              in_ch,
  input  wire logic            q_full,
  output logic                 push,
  output stls_pkg::entry_t     push_entry
);

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_SPACE  = 3'd1;
  localparam logic [2:0] M_SLASH  = 3'd2;
  localparam logic [2:0] M_LINE   = 3'd3;
  localparam logic [2:0] M_BLOCK  = 3'd4;
  localparam logic [2:0] M_STRING = 3'd5;
  localparam logic [2:0] M_WORD   = 3'd6;

  localparam logic [7:0] B_SPACE  = 8'h20;
  localparam logic [7:0] B_LF     = 8'h0A;
  localparam logic [7:0] B_SLASH  = 8'h2F;
  localparam logic [7:0] B_STAR   = 8'h2A;
  localparam logic [7:0] B_BSLASH = 8'h5C;
  localparam logic [7:0] B_DQUOTE = 8'h22;
  localparam logic [7:0] B_SQUOTE = 8'h27;
  localparam logic [7:0] B_BQUOTE = 8'h60;

  function automatic logic is_word_byte(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || (b == 8'h5F);
  endfunction

  logic [2:0]                 mode_r, mode_nxt;
  logic [7:0]                 quote_r, quote_nxt;
  logic                       esc_r, esc_nxt;
  logic                       star_r, star_nxt;
  logic [stls_pkg::LEN_W-1:0] len_r, len_nxt;
  logic                       disc_r, disc_nxt;

  logic                       accept;
  logic [7:0]                 b;
  logic                       last;
  logic [stls_pkg::LEN_W-1:0] grown;
  logic [2:0]                 st_mode;
  logic                       st_string;
  logic                       err;
  logic [1:0]                 n;
  logic [stls_pkg::CLS_W-1:0] ec [2];
  logic [stls_pkg::LEN_W-1:0] el [2];

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.source_byte;
  assign last        = in_ch.buffer_end;
  assign grown       = (len_r < stls_pkg::LEN_CAP) ? len_r + 1'b1 : len_r;

  always_comb begin
    st_string = (b == B_DQUOTE) || (b == B_SQUOTE) || (b == B_BQUOTE);
    priority if (b <= B_SPACE) begin
      st_mode = M_SPACE;
    end else if (b == B_SLASH) begin
      st_mode = M_SLASH;
    end else if (st_string) begin
      st_mode = M_STRING;
    end else if (is_word_byte(b)) begin
      st_mode = M_WORD;
    end else begin
      st_mode = M_IDLE;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    esc_nxt   = esc_r;
    star_nxt  = star_r;
    len_nxt   = len_r;
    disc_nxt  = disc_r;
    err       = 1'b0;
    n         = 2'd0;
    ec[0] = stls_pkg::CLS_SPACE;
    el[0] = '0;
    ec[1] = stls_pkg::CLS_SPACE;
    el[1] = '0;

    if (disc_r) begin
      if (last) begin
        disc_nxt = 1'b0;
      end
    end else begin
      // Close the token the byte ends (by a foreign or closing byte), then open the next one.
      unique case (mode_r)
        M_SPACE: begin
          if (b <= B_SPACE) begin
            len_nxt = grown;
          end else begin
            ec[n[0]] = stls_pkg::CLS_SPACE; el[n[0]] = len_r; n = n + 2'd1;
          end
        end
        M_WORD: begin
          if (is_word_byte(b)) begin
            len_nxt = grown;
          end else begin
            ec[n[0]] = stls_pkg::CLS_WORD; el[n[0]] = len_r; n = n + 2'd1;
          end
        end
        M_SLASH: begin
          if (b == B_SLASH) begin
            mode_nxt = M_LINE;
            len_nxt  = stls_pkg::LEN_W'(2);
          end else if (b == B_STAR) begin
            mode_nxt = M_BLOCK;
            len_nxt  = stls_pkg::LEN_W'(2);
            star_nxt = 1'b0;
          end else begin
            ec[n[0]] = stls_pkg::CLS_PUNCT; el[n[0]] = stls_pkg::LEN_W'(1); n = n + 2'd1;
          end
        end
        M_LINE: begin
          len_nxt = grown;
          if (b == B_LF) begin
            ec[n[0]] = stls_pkg::CLS_LINE; el[n[0]] = grown; n = n + 2'd1;
            mode_nxt = M_IDLE;
          end
        end
        M_BLOCK: begin
          len_nxt = grown;
          if (star_r && b == B_SLASH) begin
            ec[n[0]] = stls_pkg::CLS_BLOCK; el[n[0]] = grown; n = n + 2'd1;
            mode_nxt = M_IDLE;
            star_nxt = 1'b0;
          end else begin
            star_nxt = (b == B_STAR);
          end
        end
        M_STRING: begin
          len_nxt = grown;
          priority if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (b == B_LF) begin
            ec[n[0]] = stls_pkg::CLS_ERROR; el[n[0]] = grown; n = n + 2'd1;
            mode_nxt = M_IDLE;
            err      = 1'b1;
          end else if (b == B_BSLASH) begin
            esc_nxt = 1'b1;
          end else if (b == quote_r) begin
            ec[n[0]] = stls_pkg::CLS_STRING; el[n[0]] = grown; n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            esc_nxt = esc_r;
          end
        end
        default: begin
        end
      endcase

      if ((mode_r == M_IDLE) || (mode_r == M_SPACE && b > B_SPACE) ||
          (mode_r == M_WORD && !is_word_byte(b)) ||
          (mode_r == M_SLASH && b != B_SLASH && b != B_STAR) ||
          (mode_r == 3'd7)) begin
        len_nxt  = stls_pkg::LEN_W'(1);
        mode_nxt = st_mode;
        if (st_string) begin
          quote_nxt = b;
          esc_nxt   = 1'b0;
        end
        if (st_mode == M_IDLE) begin
          ec[n[0]] = stls_pkg::CLS_PUNCT; el[n[0]] = stls_pkg::LEN_W'(1); n = n + 2'd1;
        end
      end

      if (last) begin
        unique case (mode_nxt)
          M_SPACE: begin
            ec[n[0]] = stls_pkg::CLS_SPACE; el[n[0]] = len_nxt; n = n + 2'd1;
          end
          M_WORD: begin
            ec[n[0]] = stls_pkg::CLS_WORD; el[n[0]] = len_nxt; n = n + 2'd1;
          end
          M_SLASH: begin
            ec[n[0]] = stls_pkg::CLS_PUNCT; el[n[0]] = stls_pkg::LEN_W'(1); n = n + 2'd1;
          end
          M_LINE: begin
            ec[n[0]] = stls_pkg::CLS_LINE; el[n[0]] = len_nxt; n = n + 2'd1;
          end
          M_BLOCK, M_STRING: begin
            ec[n[0]] = stls_pkg::CLS_ERROR; el[n[0]] = len_nxt; n = n + 2'd1;
          end
          default: begin
          end
        endcase
        mode_nxt = M_IDLE;
        esc_nxt  = 1'b0;
        star_nxt = 1'b0;
        disc_nxt = 1'b0;
      end else if (err) begin
        disc_nxt = 1'b1;
      end

      if (mode_nxt == M_IDLE) begin
        esc_nxt  = 1'b0;
        star_nxt = 1'b0;
      end
    end
  end

  assign push                 = accept && (n != 2'd0);
  assign push_entry.two       = n[1];
  assign push_entry.res0.cls  = ec[0];
  assign push_entry.res0.len  = el[0];
  assign push_entry.res1.cls  = ec[1];
  assign push_entry.res1.len  = el[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      quote_r <= '0;
      esc_r   <= 1'b0;
      star_r  <= 1'b0;
      len_r   <= '0;
      disc_r  <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      esc_r   <= esc_nxt;
      star_r  <= star_nxt;
      len_r   <= len_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/stls_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stls_fifo
// Short queue of result entries between the lexer and the output stage.
// ----------------------------------------------------------------------------
module stls_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire stls_pkg::entry_t push_entry,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output stls_pkg::entry_t      head
);

  stls_pkg::entry_t                mem_r [stls_pkg::QDEPTH];
  logic [stls_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [stls_pkg::QPTR_W:0]       cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign full    = (cnt_r == (stls_pkg::QPTR_W+1)'(stls_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/stls_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stls_back
// Output stage: take entries from the queue and send their results one word
// at a time, marking the last result of each byte.
// ----------------------------------------------------------------------------
module stls_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire stls_pkg::entry_t head,
  output logic                  pop,
  stls_out_if.source            out_ch
);

  logic               out_valid_r;
  stls_pkg::result_t  out_res_r;
  logic               out_last_r;
  logic               pend_valid_r;
  stls_pkg::result_t  pend_res_r;
  logic               load;

  assign load = !out_valid_r || out_ch.ready;
  assign pop  = load && !pend_valid_r && !q_empty;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.token_class  = out_res_r.cls;
  assign out_ch.token_length = out_res_r.len;
  assign out_ch.last_of_run  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r  <= pend_valid_r || !q_empty;
      if (pend_valid_r) begin
        pend_valid_r <= 1'b0;
      end else if (!q_empty) begin
        pend_valid_r <= head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid_r) begin
        out_res_r  <= pend_res_r;
        out_last_r <= 1'b1;
      end else begin
        out_res_r  <= head.res0;
        out_last_r <= !head.two;
        pend_res_r <= head.res1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/script_lexer_token_splitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// script_lexer_token_splitter
// Byte-serial tokenizer for script source text.
// ----------------------------------------------------------------------------
// Takes one source byte per clock and reports each token (space run, line
// comment, block comment, quoted string, word, punctuation, or error) with
// its class and saturating length when it ends. A byte is accepted in every
// cycle while the four-entry result queue between the lexer and the output
// register has room; results leave at one word per clock while out_ch.ready
// holds, a byte that closes two tokens sends two words, and a stalled output
// side fills the queue before input stops. A byte's first result passes the
// queue and then the output register. After an LF inside a string the block
// drops bytes without result up to the next buffer end.
module script_lexer_token_splitter (
  input  wire logic clk,
  input  wire logic rst_n,
  stls_in_if.sink   in_ch,
  stls_out_if.source out_ch
);

  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  stls_pkg::entry_t push_entry;
  stls_pkg::entry_t head;

  stls_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  stls_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  stls_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

>>> rtl/core/stls_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stls_checker
// Port-level checks of the token splitter, bound to the top level.
// ----------------------------------------------------------------------------
module stls_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [stls_pkg::CLS_W-1:0] token_class,
  input wire logic [stls_pkg::LEN_W-1:0] token_length,
  input wire logic                       last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_class) &&
      $stable(token_length) && $stable(last_of_run))
    else $error("stalled result word changed");

  a_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> token_class <= stls_pkg::CLS_ERROR)
    else $error("token class out of range");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> token_length != '0)
    else $error("empty token reported");

  a_punct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_class == stls_pkg::CLS_PUNCT |-> token_length == 16'd1)
    else $error("punctuation longer than one byte");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind script_lexer_token_splitter stls_checker u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .token_class  (out_ch.token_class),
  .token_length (out_ch.token_length),
  .last_of_run  (out_ch.last_of_run)
);
`default_nettype wire
